// ===== hdl/svp_pkg.sv =====
package svp_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int DIFF_W  = POS_W + 1;
    localparam int SPEED_W = 16;
    localparam int ACC_W   = 16;
    localparam int PROD_W  = DIFF_W + SPEED_W;
    localparam int QUOT_W  = 48;
    localparam int VEL_W   = 32;

    // serial unit step counts
    localparam int MUL_STEPS  = SPEED_W;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int DIV_DIGIT  = 2;
    localparam int DIV_STEPS  = QUOT_W / DIV_DIGIT;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // stream packing
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 40;

    // item kinds
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RESET = 2'd1;
    localparam logic [1:0] FUNC_ESTOP = 2'd2;

    // velocity modes
    localparam logic [1:0] VMODE_PEAK  = 2'd0;
    localparam logic [1:0] VMODE_BASE  = 2'd1;
    localparam logic [1:0] VMODE_PEAK2 = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_IDX_ACCURACY = 2'd0;
    localparam logic [1:0] CFG_IDX_VMODE    = 2'd1;
    localparam logic [1:0] CFG_IDX_ZERO_POS = 2'd2;

    localparam logic [ACC_W-1:0] ACCURACY_RESET = 16'd10;

    typedef enum logic [1:0] {
        ST_READY,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } svp_state_t;

    // handshake between the sequencer and a serial unit
    typedef struct packed {
        logic start;
    } svp_unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } svp_unit_sts_t;

endpackage

// ===== hdl/svp_mul.sv =====
module svp_mul
    import svp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  svp_unit_ctl_t       ctl,
    input  logic [DIFF_W-1:0]   mcand,
    input  logic [SPEED_W-1:0]  mplier,
    output svp_unit_sts_t       sts,
    output logic [PROD_W-1:0]   product
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIFF_W-1:0]    mcand_reg, mcand_next;
    logic [DIFF_W-1:0]    hi_reg, hi_next;
    logic [SPEED_W-1:0]   lo_reg, lo_next;
    logic [DIFF_W:0]      sum;

    // shift-add, one multiplier bit per cycle, lsb first
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        sum        = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        if (ctl.start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = mcand;
            hi_next    = '0;
            lo_next    = mplier;
        end else if (busy_reg) begin
            hi_next  = sum[DIFF_W:1];
            lo_next  = {sum[0], lo_reg[SPEED_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign product  = {hi_reg, lo_reg};
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ===== hdl/svp_div.sv =====
module svp_div
    import svp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  svp_unit_ctl_t       ctl,
    input  logic [QUOT_W-1:0]   dividend,
    input  logic [SPEED_W-1:0]  divisor,
    output svp_unit_sts_t       sts,
    output logic [QUOT_W-1:0]   quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SPEED_W-1:0]   dsr_reg, dsr_next;
    logic [SPEED_W-1:0]   rem_reg, rem_next;
    logic [QUOT_W-1:0]    dq_reg, dq_next;
    logic [SPEED_W:0]     step_a, step_b;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [SPEED_W:0] div_step(
        input logic [SPEED_W-1:0] rem,
        input logic               in_bit,
        input logic [SPEED_W-1:0] d
    );
        logic [SPEED_W:0] trial;
        logic [SPEED_W:0] diff;
        trial = {rem, in_bit};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            return {1'b1, diff[SPEED_W-1:0]};
        end
        return {1'b0, trial[SPEED_W-1:0]};
    endfunction

    // radix 4: two dividend bits per cycle, msb first; quotient shifts in at the bottom
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        step_a    = div_step(rem_reg, dq_reg[QUOT_W-1], dsr_reg);
        step_b    = div_step(step_a[SPEED_W-1:0], dq_reg[QUOT_W-2], dsr_reg);
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dsr_next  = divisor;
            rem_next  = '0;
            dq_next   = dividend;
        end else if (busy_reg) begin
            rem_next = step_b[SPEED_W-1:0];
            dq_next  = {dq_reg[QUOT_W-3:0], step_a[SPEED_W], step_b[SPEED_W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign quotient = dq_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ===== hdl/segment_velocity_planner_top.sv =====
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------------------
// s_        | in        | s_tvalid / s_tready    | s_tdata: tick fields, s_tuser: item kind
// m_        | out       | m_tvalid / m_tready    | m_tdata: velocity, working, saturated
// cfg_      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data (register write)
//
// a tick that computes a velocity runs the bit-serial multiplier, then the radix-4 serial
// divider, with accept, hand-over and output steps around them
// every other transaction (reset, estop, idle tick, arrival, run clear, hold) skips both units
// one transaction is in work at a time; the next one is taken while a result waits in m_
// aresetn is synchronous, active low; it clears state, config and the output valid
// a stalled m_ side holds the finished result; the sequencer waits in its done state
module segment_velocity_planner_top
    import svp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // item in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // measured_position[31:0], run_flag[32], section_target[64:33],
    // section_distance[80:65], peak_speed[96:81], base_speed[112:97], zero pad
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // func[1:0]
    input  logic [1:0]             s_tuser,
    // result out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // velocity_command[31:0], working[32], saturated[33], zero pad
    output logic [M_TDATA_W-1:0]   m_tdata,
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [POS_W-1:0]       cfg_data
);

    // input field unpacking
    logic signed [POS_W-1:0] meas;
    logic                    run;
    logic signed [POS_W-1:0] target;
    logic [SPEED_W-1:0]      sect_dist;
    logic [SPEED_W-1:0]      peak;
    logic [SPEED_W-1:0]      base;
    logic [1:0]              func;

    assign meas      = s_tdata[31:0];
    assign run       = s_tdata[32];
    assign target    = s_tdata[64:33];
    assign sect_dist = s_tdata[80:65];
    assign peak      = s_tdata[96:81];
    assign base      = s_tdata[112:97];
    assign func      = s_tuser;

    // configuration registers
    logic [ACC_W-1:0]        accuracy_reg;
    logic [1:0]              vmode_reg;
    logic [POS_W-1:0]        zero_pos_reg;

    // planner state
    svp_state_t              state_reg, state_next;
    logic                    mode_work_reg, mode_work_next;
    logic [POS_W-1:0]        start_pos_reg, start_pos_next;
    logic [VEL_W-1:0]        last_vel_reg, last_vel_next;
    logic                    sat_reg, sat_next;

    // working payload for the serial units
    logic                    neg_reg, neg_next;
    logic [SPEED_W-1:0]      dist_reg, dist_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg, m_data_next;

    // serial units
    svp_unit_ctl_t           mul_ctl, div_ctl;
    svp_unit_sts_t           mul_sts, div_sts;
    logic [DIFF_W-1:0]       mul_mcand;
    logic [SPEED_W-1:0]      mul_mplier;
    logic [PROD_W-1:0]       mul_prod;
    logic [QUOT_W-1:0]       div_quot;

    // tick decode: position error and target offset from the start point, both exact in 33 bits
    logic [DIFF_W-1:0]       err;
    logic [DIFF_W-1:0]       err_abs;
    logic [DIFF_W-1:0]       diff;
    logic [DIFF_W-1:0]       diff_abs;
    logic                    arrived;
    logic [SPEED_W-1:0]      speed;
    logic                    speed_ok;

    always_comb begin
        err      = {meas[POS_W-1], meas} - {target[POS_W-1], target};
        err_abs  = err[DIFF_W-1] ? (~err + 1'b1) : err;
        arrived  = err_abs < {{(DIFF_W-ACC_W){1'b0}}, accuracy_reg};
        diff     = {target[POS_W-1], target} - {start_pos_reg[POS_W-1], start_pos_reg};
        diff_abs = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
        speed    = '0;
        speed_ok = 1'b0;
        case (vmode_reg)
            VMODE_PEAK, VMODE_PEAK2: begin
                speed    = peak;
                speed_ok = 1'b1;
            end
            VMODE_BASE: begin
                speed    = base;
                speed_ok = 1'b1;
            end
            default: begin
                speed_ok = 1'b0;
            end
        endcase
        // zero distance and zero peak speed skip in every mode
        speed_ok = speed_ok && (speed != '0) && (sect_dist != '0) && (peak != '0);
    end

    assign mul_mcand  = diff_abs;
    assign mul_mplier = speed;

    // saturation of the signed quotient
    logic                    pos_over;
    logic                    neg_over;
    logic [VEL_W-1:0]        quot_lo;

    assign quot_lo  = div_quot[VEL_W-1:0];
    assign pos_over = |div_quot[QUOT_W-1:VEL_W-1];
    assign neg_over = (|div_quot[QUOT_W-1:VEL_W])
                      || (div_quot[VEL_W-1] && (|div_quot[VEL_W-2:0]));

    // sequencer
    always_comb begin
        state_next     = state_reg;
        mode_work_next = mode_work_reg;
        start_pos_next = start_pos_reg;
        last_vel_next  = last_vel_reg;
        sat_next       = sat_reg;
        neg_next       = neg_reg;
        dist_next      = dist_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        mul_ctl.start  = 1'b0;
        div_ctl.start  = 1'b0;
        s_tready       = 1'b0;

        // output transaction completes
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_READY: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sat_next   = 1'b0;
                    state_next = ST_DONE;
                    neg_next   = diff[DIFF_W-1];
                    dist_next  = sect_dist;
                    case (func)
                        FUNC_RESET: begin
                            last_vel_next  = '0;
                            mode_work_next = 1'b0;
                        end
                        FUNC_ESTOP: begin
                            last_vel_next = '0;
                        end
                        FUNC_TICK: begin
                            if (!mode_work_reg) begin
                                // leaving idle latches the configured start point
                                if (run) begin
                                    mode_work_next = 1'b1;
                                    start_pos_next = zero_pos_reg;
                                end
                            end else if (arrived) begin
                                last_vel_next  = '0;
                                start_pos_next = meas;
                            end else if (run) begin
                                if (speed_ok) begin
                                    mul_ctl.start = 1'b1;
                                    state_next    = ST_MUL;
                                end
                            end else begin
                                last_vel_next = '0;
                            end
                        end
                        default: begin
                            // unused kind: report current values
                        end
                    endcase
                end
            end
            ST_MUL: begin
                if (mul_sts.done) begin
                    // product stays below 2^48
                    div_ctl.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    state_next = ST_DONE;
                    if (!neg_reg) begin
                        if (pos_over) begin
                            last_vel_next = {1'b0, {(VEL_W-1){1'b1}}};
                            sat_next      = 1'b1;
                        end else begin
                            last_vel_next = quot_lo;
                        end
                    end else begin
                        if (neg_over) begin
                            last_vel_next = {1'b1, {(VEL_W-1){1'b0}}};
                            sat_next      = 1'b1;
                        end else begin
                            last_vel_next = ~quot_lo + 1'b1;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(M_TDATA_W-VEL_W-2){1'b0}}, sat_reg, mode_work_reg,
                                    last_vel_reg};
                    state_next   = ST_READY;
                end
            end
            default: begin
                state_next = ST_READY;
            end
        endcase
    end

    // config writes must land only while idle; the block does not enforce it and the port is always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accuracy_reg  <= ACCURACY_RESET;
            vmode_reg     <= VMODE_PEAK;
            zero_pos_reg  <= '0;
            state_reg     <= ST_READY;
            mode_work_reg <= 1'b0;
            start_pos_reg <= '0;
            last_vel_reg  <= '0;
            sat_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_work_reg <= mode_work_next;
            start_pos_reg <= start_pos_next;
            last_vel_reg  <= last_vel_next;
            sat_reg       <= sat_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IDX_ACCURACY: accuracy_reg <= cfg_data[ACC_W-1:0];
                    CFG_IDX_VMODE:    vmode_reg    <= cfg_data[1:0];
                    CFG_IDX_ZERO_POS: zero_pos_reg <= cfg_data;
                    default: begin
                        // writes beyond the register list are dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg    <= neg_next;
        dist_reg   <= dist_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    svp_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mul_ctl),
        .mcand    (mul_mcand),
        .mplier   (mul_mplier),
        .sts      (mul_sts),
        .product  (mul_prod)
    );

    svp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (mul_prod[QUOT_W-1:0]),
        .divisor  (dist_reg),
        .sts      (div_sts),
        .quotient (div_quot)
    );

    // serial unit results only show up in the state that waits for them
    a_mul_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_sts.done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside its state");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its state");

    // the two units never run at the same time
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_sts.busy && div_sts.busy))
        else $error("multiplier and divider busy together");

    // a free output register takes the result in the done state
    a_done_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_tready)) |=> m_valid_reg)
        else $error("finished result not presented");

endmodule

// ===== dv/segment_velocity_planner_top_tb.sv =====
module segment_velocity_planner_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import svp_pkg::*;

    // codes that the package leaves unnamed
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [1:0] VMODE_HOLD = 2'd3;

    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
    localparam longint VEL_HI = 2147483647;
    localparam longint VEL_LO = -longint'(2147483647) - 1;

    // generous cap, far above the slowest legal run
    localparam int CYCLE_LIMIT = 1_000_000;

    // one tick, reset or estop as it travels on the s_ channel
    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] meas;
        logic               run;
        logic signed [31:0] target;
        logic [15:0]        distance;
        logic [15:0]        peak;
        logic [15:0]        base;
    } tick_item_t;

    // one velocity result as it leaves on the m_ channel
    typedef struct packed {
        logic signed [31:0] vel;
        logic               working;
        logic               sat;
    } velocity_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [POS_W-1:0]     cfg_data  = '0;

    // planner state as the testbench sees it, reset values
    logic               plan_working = 1'b0;
    logic signed [31:0] start_pos    = '0;
    logic signed [31:0] last_vel     = '0;
    // register copies, reset values
    logic [15:0]        acc_window   = 16'd10;
    logic [1:0]         vmode        = VMODE_PEAK;
    logic signed [31:0] zero_pos     = '0;

    // results still owed by the block, oldest first
    velocity_result_t pending_velocities[$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  ready_hold  = 0;
    // set for the last stretch: no idling on either side
    bit  calm        = 1'b0;

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    segment_velocity_planner_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("segment_velocity_planner_top_tb: done, errors");
            $finish;
        end
    end

    // result side back-pressure: random bursts of ready and stall
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= ($urandom_range(0, 2) != 0);
            ready_hold <= $urandom_range(0, 7);
        end
    end

    // compare every result transaction with the oldest owed velocity
    always @(posedge aclk) begin
        velocity_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_velocities.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: vel %0d working %0b sat %0b",
                             $signed(m_tdata[31:0]), m_tdata[32], m_tdata[33]);
                mismatches++;
            end else begin
                want = pending_velocities.pop_front();
                if (m_tdata[31:0] !== want.vel || m_tdata[32] !== want.working ||
                    m_tdata[33] !== want.sat) begin
                    if (mismatches < 10)
                        $display({"mismatch: exp vel %0d working %0b sat %0b, ",
                                  "got vel %0d working %0b sat %0b"},
                                 want.vel, want.working, want.sat,
                                 $signed(m_tdata[31:0]), m_tdata[32], m_tdata[33]);
                    mismatches++;
                end
            end
        end
    end

    // next planner state and the result it reports for one accepted item
    function automatic velocity_result_t plan_velocity(input tick_item_t it);
        velocity_result_t r;
        longint err;
        longint diff;
        longint spd;
        longint q;
        bit     ok;
        r.sat = 1'b0;
        case (it.func)
            FUNC_RESET: begin
                last_vel     = '0;
                plan_working = 1'b0;
            end
            FUNC_ESTOP: begin
                last_vel = '0;
            end
            FUNC_TICK: begin
                if (!plan_working) begin
                    // leaving idle latches the programmed start point
                    if (it.run) begin
                        plan_working = 1'b1;
                        start_pos    = zero_pos;
                    end
                end else begin
                    err = longint'(it.meas) - longint'(it.target);
                    if (err < 0)
                        err = -err;
                    if (err < longint'(acc_window)) begin
                        // arrived: stop and restart from here
                        last_vel  = '0;
                        start_pos = it.meas;
                    end else if (it.run) begin
                        // peak speed must be nonzero even when base speed is used
                        ok = (it.distance != 0) && (it.peak != 0);
                        case (vmode)
                            VMODE_PEAK, VMODE_PEAK2: spd = longint'(it.peak);
                            VMODE_BASE:              spd = longint'(it.base);
                            default: begin
                                spd = 0;
                                ok  = 1'b0;
                            end
                        endcase
                        if (spd == 0)
                            ok = 1'b0;
                        if (ok) begin
                            diff = longint'(it.target) - longint'(start_pos);
                            q    = (diff * spd) / longint'(it.distance);
                            if (q > VEL_HI) begin
                                q     = VEL_HI;
                                r.sat = 1'b1;
                            end else if (q < VEL_LO) begin
                                q     = VEL_LO;
                                r.sat = 1'b1;
                            end
                            last_vel = q[31:0];
                        end
                    end else begin
                        last_vel = '0;
                    end
                end
            end
            default: ;
        endcase
        r.vel     = last_vel;
        r.working = plan_working;
        return r;
    endfunction

    function automatic tick_item_t make_item(input logic [1:0] func,
                                             input logic signed [31:0] meas,
                                             input logic run,
                                             input logic signed [31:0] target,
                                             input logic [15:0] distance,
                                             input logic [15:0] peak,
                                             input logic [15:0] base);
        tick_item_t it;
        it.func     = func;
        it.meas     = meas;
        it.run      = run;
        it.target   = target;
        it.distance = distance;
        it.peak     = peak;
        it.base     = base;
        return it;
    endfunction

    // full range, close to a reference, or one of the corners
    function automatic logic signed [31:0] pick_position(input logic signed [31:0] ref_pos);
        int off;
        case ($urandom_range(0, 3))
            0: return $urandom();
            1, 2: begin
                off = int'($urandom_range(0, 100000)) - 50000;
                return ref_pos + off;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       return POS_MIN;
                    1:       return POS_MAX;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_speed();
        if ($urandom_range(0, 9) == 0)
            return 16'd0;
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom_range(1, 300));
        return 16'($urandom());
    endfunction

    // mostly working ticks with random content, some stops, resets and spare codes
    function automatic tick_item_t random_tick();
        tick_item_t it;
        int         pick;
        int         w;
        int         off;
        pick = $urandom_range(0, 99);
        if (pick < 86)
            it.func = FUNC_TICK;
        else if (pick < 92)
            it.func = FUNC_ESTOP;
        else if (pick < 97)
            it.func = FUNC_RESET;
        else
            it.func = FUNC_SPARE;
        it.run    = ($urandom_range(0, 7) != 0);
        it.target = pick_position(start_pos);
        if ($urandom_range(0, 4) == 0) begin
            // land inside or just around the arrival window
            w      = (acc_window < 16'd1000) ? int'(acc_window) + 1 : 1000;
            off    = int'($urandom_range(0, 2 * w)) - w;
            it.meas = it.target + off;
        end else begin
            it.meas = pick_position(it.target);
        end
        if ($urandom_range(0, 9) == 0)
            it.distance = 16'd0;
        else if ($urandom_range(0, 1) == 0)
            it.distance = 16'($urandom_range(1, 64));
        else
            it.distance = 16'($urandom());
        it.peak = pick_speed();
        it.base = pick_speed();
        return it;
    endfunction

    // one item transaction on s_, with an optional random gap in front
    task automatic send_item(input tick_item_t it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {7'd0, it.base, it.peak, it.distance, it.target, it.run, it.meas};
        do @(posedge aclk); while (!s_tready);
        pending_velocities.push_back(plan_velocity(it));
    endtask

    // sender stops until every owed result has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_velocities.size() != 0);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_IDX_ACCURACY: acc_window = data[15:0];
            CFG_IDX_VMODE:    vmode      = data[1:0];
            CFG_IDX_ZERO_POS: zero_pos   = data;
            default: ;
        endcase
    endtask

    // all three registers, only with the block idle
    task automatic set_config(input logic [15:0] acc, input logic [1:0] mode,
                              input logic signed [31:0] zpos);
        hold_until_drained();
        write_register(CFG_IDX_ACCURACY, {16'd0, acc});
        write_register(CFG_IDX_VMODE, {30'd0, mode});
        write_register(CFG_IDX_ZERO_POS, zpos);
        cfg_valid <= 1'b0;
    endtask

    // idle ignores run clear and the spare code, run set enters work
    task automatic test_idle_entry();
        send_item(make_item(FUNC_TICK, 123, 1'b0, 456, 16'd1, 16'd1, 16'd1));
        send_item(make_item(FUNC_SPARE, -1, 1'b1, -1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_item(FUNC_TICK, 0, 1'b1, 1000, 16'd100, 16'd3, 16'd0));
    endtask

    // work-state paths under the reset configuration
    task automatic test_velocity_paths();
        send_item(make_item(FUNC_TICK, 0, 1'b1, 1000, 16'd100, 16'd3, 16'd0));
        // negative quotient truncates toward zero
        send_item(make_item(FUNC_TICK, 100, 1'b1, -7, 16'd2, 16'd1, 16'd0));
        // zero distance and zero peak speed hold the velocity
        send_item(make_item(FUNC_TICK, 100, 1'b1, -7, 16'd0, 16'd1, 16'd0));
        send_item(make_item(FUNC_TICK, 100, 1'b1, -7, 16'd2, 16'd0, 16'd9));
        // run clear away from the target stops
        send_item(make_item(FUNC_TICK, 100, 1'b0, -7, 16'd2, 16'd1, 16'd0));
        // error just inside and exactly on the window edge
        send_item(make_item(FUNC_TICK, 14, 1'b0, 5, 16'd1, 16'd1, 16'd1));
        send_item(make_item(FUNC_TICK, 15, 1'b1, 5, 16'd1, 16'd1, 16'd1));
        send_item(make_item(FUNC_ESTOP, 0, 1'b1, 0, 16'd1, 16'd1, 16'd1));
        // arrival at the bottom corner, then clip high
        send_item(make_item(FUNC_TICK, POS_MIN, 1'b1, POS_MIN + 5, 16'd1, 16'd1, 16'd1));
        send_item(make_item(FUNC_TICK, 0, 1'b1, POS_MAX, 16'd1, 16'hFFFF, 16'd0));
        // arrival at the top corner, then clip low
        send_item(make_item(FUNC_TICK, POS_MAX, 1'b1, POS_MAX - 3, 16'd1, 16'd1, 16'd1));
        send_item(make_item(FUNC_TICK, 0, 1'b1, POS_MIN, 16'd1, 16'hFFFF, 16'd0));
        // widest position error
        send_item(make_item(FUNC_TICK, POS_MIN, 1'b1, POS_MAX, 16'hFFFF, 16'd1, 16'hFFFF));
        send_item(make_item(FUNC_RESET, 77, 1'b1, 77, 16'd1, 16'd1, 16'd1));
    endtask

    // register extremes and the base, hold and second peak velocity modes
    task automatic test_register_settings();
        set_config(16'd0, VMODE_BASE, POS_MIN);
        send_item(make_item(FUNC_TICK, 0, 1'b1, 0, 16'd1, 16'd1, 16'd1));
        // zero window never counts as arrived
        send_item(make_item(FUNC_TICK, 0, 1'b1, 0, 16'd1, 16'd1, 16'hFFFF));
        send_item(make_item(FUNC_TICK, 0, 1'b1, 0, 16'd1, 16'd1, 16'd0));
        send_item(make_item(FUNC_TICK, 0, 1'b1, 0, 16'd1, 16'd0, 16'd5));
        set_config(16'hFFFF, VMODE_HOLD, POS_MAX);
        send_item(make_item(FUNC_TICK, 0, 1'b1, 70000, 16'd1, 16'd1, 16'd1));
        send_item(make_item(FUNC_TICK, 0, 1'b1, 65534, 16'd1, 16'd1, 16'd1));
        send_item(make_item(FUNC_RESET, 0, 1'b0, 0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(FUNC_TICK, 0, 1'b1, 0, 16'd0, 16'd0, 16'd0));
        set_config(16'd10, VMODE_PEAK2, 32'sd0);
        send_item(make_item(FUNC_TICK, 0, 1'b1, -1000, 16'd10, 16'd7, 16'd0));
    endtask

    // six phases of 300 random items, each under its own configuration
    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(16'd10, VMODE_PEAK, 32'sd0);
                1: set_config(16'($urandom_range(0, 200)), VMODE_BASE, $urandom());
                2: set_config(16'hFFFF, VMODE_PEAK2, POS_MAX);
                3: set_config(16'd0, VMODE_HOLD, POS_MIN);
                4: set_config(16'($urandom()), 2'($urandom()), $urandom());
                default: begin
                    set_config(16'($urandom_range(1, 50)), VMODE_PEAK, $urandom());
                    // final stretch runs at full rate on both sides
                    calm = 1'b1;
                end
            endcase
            for (int n = 0; n < 300; n++) begin
                // one pause mid-phase with nothing in flight
                if (p == 1 && n == 150)
                    hold_until_drained();
                send_item(random_tick());
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_entry();
        test_velocity_paths();
        test_register_settings();
        test_random_phases();
        hold_until_drained();
        // room for any stray result beyond the last owed one
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("segment_velocity_planner_top_tb: done, clean");
        end else begin
            $display("segment_velocity_planner_top_tb: done, errors");
        end
        $finish;
    end

endmodule
